### src/mt19937_uniform_range_draw_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the uniform range draw block
// Concurrent assertion shorthands clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef MT19937_UNIFORM_RANGE_DRAW_MACROS_SVH
`define MT19937_UNIFORM_RANGE_DRAW_MACROS_SVH

// Checked at every edge, reset included.
`define MTURD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define MTURD_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### src/mturd_pkg.sv
// ----------------------------------------------------------------------------
// mturd_pkg
// Shared constants, state encoding and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mturd_pkg;

  localparam int unsigned MT_N = 624;
  localparam int unsigned MT_M = 397;
  localparam int unsigned IDX_W = 10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MT_N - 1);
  localparam logic [IDX_W-1:0] END_POS = IDX_W'(MT_N);
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] INIT_MULT = 32'd1812433253;
  localparam logic [31:0] MATRIX_A = 32'h9908B0DF;
  localparam logic [31:0] FULL_WORD = 32'hFFFFFFFF;
  localparam logic [5:0] DIV_STEPS = 6'd32;

  // Request kinds carried on tuser.
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [1:0] {
    RD_POS,
    RD_IDX,
    RD_NEXT,
    RD_FAR
  } rd_sel_t;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_SEED_WR,
    ST_SEED_MUL,
    ST_SEED_ADD,
    ST_DIV_LIM,
    ST_FETCH,
    ST_WORD_CAP,
    ST_CHECK,
    ST_DIV_VAL,
    ST_TW_RD0,
    ST_TW_RD1,
    ST_TW_RD2,
    ST_TW_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    item_load;
    logic    seed_boot;
    logic    seed_mul;
    logic    seed_add;
    logic    seed_wr;
    logic    seed_end;
    logic    div_start;
    logic    div_src_word;
    logic    lim_set;
    rd_sel_t rd_sel;
    logic    word_cap;
    logic    tw_cap_a;
    logic    tw_cap_b;
    logic    tw_wr;
    logic    idx_clr;
    logic    idx_inc;
    logic    pos_clr;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic item_restart;
    logic item_zero;
    logic idx_last;
    logic pos_end;
    logic div_busy;
    logic reject;
    logic out_busy;
  } sts_t;

endpackage

### src/mturd_ram.sv
// ----------------------------------------------------------------------------
// mturd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mturd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mturd_ctrl.sv
// ----------------------------------------------------------------------------
// mturd_ctrl
// Sequencer for seeding, state regeneration, rejection sampling and results.
// ----------------------------------------------------------------------------
module mturd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  mturd_pkg::sts_t sts,
  output mturd_pkg::cmd_t cmd
);
  import mturd_pkg::*;

  state_t state, state_next;
  logic   boot, boot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT;
      boot  <= 1'b1;
    end else begin
      state <= state_next;
      boot  <= boot_next;
    end
  end

  always_comb begin
    state_next = state;
    boot_next  = boot;
    cmd        = '0;
    cmd.rd_sel = RD_POS;
    in_ready   = 1'b0;
    unique case (state)
      ST_BOOT: begin
        cmd.seed_boot = 1'b1;
        state_next    = ST_SEED_WR;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.item_load = 1'b1;
          priority if (sts.item_restart) begin
            state_next = ST_SEED_WR;
          end else if (sts.item_zero) begin
            state_next = ST_DONE;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIV_LIM;
          end
        end
      end
      ST_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.seed_end = 1'b1;
          boot_next    = 1'b0;
          state_next   = boot ? ST_IDLE : ST_DONE;
        end else begin
          state_next = ST_SEED_MUL;
        end
      end
      ST_SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_next   = ST_SEED_ADD;
      end
      ST_SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_next   = ST_SEED_WR;
      end
      ST_DIV_LIM: begin
        if (!sts.div_busy) begin
          cmd.lim_set = 1'b1;
          state_next  = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (sts.pos_end) begin
          cmd.idx_clr = 1'b1;
          state_next  = ST_TW_RD0;
        end else begin
          cmd.rd_sel = RD_POS;
          state_next = ST_WORD_CAP;
        end
      end
      ST_WORD_CAP: begin
        cmd.word_cap = 1'b1;
        state_next   = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.reject) begin
          state_next = ST_FETCH;
        end else begin
          cmd.div_start    = 1'b1;
          cmd.div_src_word = 1'b1;
          state_next       = ST_DIV_VAL;
        end
      end
      ST_DIV_VAL: begin
        if (!sts.div_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_TW_RD0: begin
        cmd.rd_sel = RD_IDX;
        state_next = ST_TW_RD1;
      end
      ST_TW_RD1: begin
        cmd.tw_cap_a = 1'b1;
        cmd.rd_sel   = RD_NEXT;
        state_next   = ST_TW_RD2;
      end
      ST_TW_RD2: begin
        cmd.tw_cap_b = 1'b1;
        cmd.rd_sel   = RD_FAR;
        state_next   = ST_TW_WR;
      end
      ST_TW_WR: begin
        cmd.tw_wr = 1'b1;
        if (sts.idx_last) begin
          cmd.pos_clr = 1'b1;
          state_next  = ST_FETCH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = ST_TW_RD0;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/mturd_dp.sv
// ----------------------------------------------------------------------------
// mturd_dp
// Generator state memory, seeding multiplier, twist, tempering, bit-serial
// remainder unit, counters and the output register.
// ----------------------------------------------------------------------------
module mturd_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic            seed_we,
  input  logic [31:0]     seed_wdata,
  input  logic            in_kind,
  input  logic [31:0]     in_range,
  input  mturd_pkg::cmd_t cmd,
  output mturd_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     out_value,
  output logic [31:0]     out_total
);
  import mturd_pkg::*;

  logic [31:0]      seed;
  logic [31:0]      draw_count;
  logic [31:0]      rng;
  logic             zero_res;
  logic [31:0]      prev;
  logic [31:0]      prod;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] pos;
  logic [31:0]      tw_a;
  logic [31:0]      tw_b;
  logic [31:0]      word;
  logic [31:0]      limit;
  logic [31:0]      rem;
  logic [31:0]      dq;
  logic [5:0]       bcnt;

  logic [IDX_W-1:0] raddr;
  logic [31:0]      rdata;
  logic             we;
  logic [31:0]      wdata;
  logic [IDX_W-1:0] idx_next1;
  logic [IDX_W:0]   far_sum;
  logic [IDX_W-1:0] idx_far;
  logic [31:0]      mix;
  logic [31:0]      twist;
  logic [31:0]      tmp0, tmp1, tmp2, tempered;
  logic [32:0]      trial;

  assign idx_next1 = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  assign far_sum   = {1'b0, idx} + (IDX_W+1)'(MT_M);
  assign idx_far   = (far_sum >= (IDX_W+1)'(MT_N)) ?
                     IDX_W'(far_sum - (IDX_W+1)'(MT_N)) : far_sum[IDX_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      RD_POS:  raddr = pos;
      RD_IDX:  raddr = idx;
      RD_NEXT: raddr = idx_next1;
      RD_FAR:  raddr = idx_far;
      default: raddr = pos;
    endcase
  end

  // Twist: the far word arrives on the read port in the write cycle.
  assign mix   = {tw_a[31], tw_b[30:0]};
  assign twist = rdata ^ {1'b0, mix[31:1]} ^ (mix[0] ? MATRIX_A : 32'd0);

  assign tmp0     = rdata ^ {11'd0, rdata[31:11]};
  assign tmp1     = tmp0 ^ ({tmp0[24:0], 7'd0} & 32'h9D2C5680);
  assign tmp2     = tmp1 ^ ({tmp1[16:0], 15'd0} & 32'hEFC60000);
  assign tempered = tmp2 ^ {18'd0, tmp2[31:18]};

  assign we    = cmd.seed_wr | cmd.tw_wr;
  assign wdata = cmd.seed_wr ? prev : twist;

  mturd_ram #(
    .WIDTH(32),
    .DEPTH(MT_N)
  ) u_words (
    .clk  (clk),
    .we   (we),
    .waddr(idx),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign trial = {rem, dq[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      seed       <= '0;
      draw_count <= '0;
      pos        <= END_POS;
      bcnt       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (seed_we) begin
        seed <= seed_wdata;
      end
      if (cmd.item_load) begin
        if (in_kind == KIND_RESTART) begin
          draw_count <= '0;
        end else if (in_range != 32'd0) begin
          draw_count <= draw_count + 32'd1;
        end
      end
      if (cmd.seed_end) begin
        pos <= END_POS;
      end else if (cmd.pos_clr) begin
        pos <= '0;
      end else if (cmd.word_cap) begin
        pos <= pos + 1'b1;
      end
      if (cmd.div_start) begin
        bcnt <= DIV_STEPS;
      end else if (bcnt != 6'd0) begin
        bcnt <= bcnt - 6'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      rng      <= in_range;
      zero_res <= (in_kind == KIND_RESTART) | (in_range == 32'd0);
      prev     <= seed;
      idx      <= '0;
    end else if (cmd.seed_boot) begin
      prev <= DEFAULT_SEED;
      idx  <= '0;
    end else if (cmd.seed_add) begin
      prev <= prod + 32'(idx) + 32'd1;
      idx  <= idx + 1'b1;
    end else if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.seed_mul) begin
      prod <= INIT_MULT * (prev ^ {30'd0, prev[31:30]});
    end
    if (cmd.tw_cap_a) begin
      tw_a <= rdata;
    end
    if (cmd.tw_cap_b) begin
      tw_b <= rdata;
    end
    if (cmd.word_cap) begin
      word <= tempered;
    end
    if (cmd.lim_set) begin
      limit <= FULL_WORD - rem;
    end
    // Restoring remainder, one dividend bit per cycle.
    if (cmd.div_start) begin
      rem <= '0;
      dq  <= cmd.div_src_word ? word : FULL_WORD;
    end else if (bcnt != 6'd0) begin
      rem <= (trial >= {1'b0, rng}) ? 32'(trial - {1'b0, rng}) : trial[31:0];
      dq  <= {dq[30:0], 1'b0};
    end
    if (cmd.out_load) begin
      out_value <= zero_res ? 32'd0 : rem;
      out_total <= draw_count;
    end
  end

  always_comb begin
    sts.item_restart = (in_kind == KIND_RESTART);
    sts.item_zero    = (in_range == 32'd0);
    sts.idx_last     = (idx == LAST_IDX);
    sts.pos_end      = (pos >= END_POS);
    sts.div_busy     = (bcnt != 6'd0);
    sts.reject       = (word >= limit);
    sts.out_busy     = out_valid;
  end

endmodule

### src/mt19937_uniform_range_draw.sv
// ----------------------------------------------------------------------------
// mt19937_uniform_range_draw
// Uniform draw below a requested range from an MT19937 word stream, with
// rejection of the biased top of the word space.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata / payload                    | tuser
//  s_*       | in  | [31:0] range                       | kind (1 = restart)
//  m_*       | out | [31:0] value, [63:32] draw_total   | -
//  seed_*    | in  | seed_wdata [31:0], write on seed_we| -
//
// A draw runs two 32-step bit-serial remainders (the limit and the value) and
// fetches and tempers words until one falls below the limit. Regenerating the
// 624-word state reads and rewrites each word in turn through its one read
// port. A zero range skips the remainders; a restart reseeds the state.
// After reset the block seeds itself with 5489, s_tready low.
// A request is taken while the previous result still waits in the output
// register; the new result holds until m_tready frees that register.
module mt19937_uniform_range_draw (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] range
  input  logic        s_tuser,    // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,    // [31:0] value, [63:32] draw_total
  input  logic        seed_we,
  input  logic [31:0] seed_wdata
);
  import mturd_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] out_value;
  logic [31:0] out_total;

  mturd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mturd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata),
    .in_kind   (s_tuser),
    .in_range  (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (out_value),
    .out_total (out_total)
  );

  assign m_tdata = {out_total, out_value};

endmodule

### src/mturd_checker.sv
// ----------------------------------------------------------------------------
// mturd_checker
// Port-level checks on the uniform range draw block, bound to its top level.
// ----------------------------------------------------------------------------
`include "mt19937_uniform_range_draw_macros.svh"

module mturd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);

  // The generator seeds itself after reset, so no request is taken at once.
  `MTURD_ASSERT(a_boot_busy, rst |=> !s_tready, "request taken right after reset")

  `MTURD_ASSERT(a_no_result_after_rst, rst |=> !m_tvalid, "result shown after reset")

  // Only one request is worked on at a time.
  `MTURD_ASSERT_RUN(a_one_in_flight, s_tvalid && s_tready |=> !s_tready,
    "second request taken back to back")

  `MTURD_ASSERT_RUN(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata),
    "stalled result changed")

  // Every value is below a 32-bit range, so the all-ones word never appears.
  `MTURD_ASSERT_RUN(a_value_bound, m_tvalid |-> m_tdata[31:0] != 32'hFFFFFFFF,
    "value out of range")

endmodule

bind mt19937_uniform_range_draw mturd_checker u_mturd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

### sim/mturd_draw_checker.sv
// ----------------------------------------------------------------------------
// Draw result checker
// Watches the request, result and seed channels of the uniform range draw
// block, keeps its own MT19937 generator, and compares every result in order.
// ----------------------------------------------------------------------------
module mturd_draw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [63:0] m_tdata,
  input  logic        seed_we,
  input  logic [31:0] seed_wdata,
  output int          pending,
  output int          errors
);
  import mturd_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] draw_total;
  } draw_result_t;

  logic [31:0]  mt_words [MT_N];
  int unsigned  mt_pos;
  logic [31:0]  draw_tally;
  logic [31:0]  seed_reg;
  draw_result_t awaited_results[$];

  assign pending = awaited_results.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %08h, expected %08h", what, got, want);
    errors++;
  endtask

  task automatic seed_words(input logic [31:0] s);
    logic [31:0] prev;
    prev = s;
    mt_words[0] = s;
    for (int i = 1; i < MT_N; i++) begin
      prev = INIT_MULT * (prev ^ (prev >> 30)) + 32'(i);
      mt_words[i] = prev;
    end
    mt_pos = MT_N;
  endtask

  task automatic twist_words();
    logic [31:0] y;
    logic [31:0] w;
    for (int i = 0; i < MT_N; i++) begin
      y = {mt_words[i][31], mt_words[(i + 1) % MT_N][30:0]};
      w = mt_words[(i + MT_M) % MT_N] ^ (y >> 1);
      if (y[0]) begin
        w = w ^ MATRIX_A;
      end
      mt_words[i] = w;
    end
    mt_pos = 0;
  endtask

  task automatic pull_word(output logic [31:0] y);
    if (mt_pos >= MT_N) begin
      twist_words();
    end
    y = mt_words[mt_pos];
    mt_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
  endtask

  task automatic predict_draw(input logic kind, input logic [31:0] range);
    draw_result_t r;
    logic [31:0]  limit;
    logic [31:0]  w;
    r.value = '0;
    if (kind == KIND_RESTART) begin
      seed_words(seed_reg);
      draw_tally = '0;
    end else if (range != 0) begin
      // Words in the top partial bucket would bias the remainder.
      limit = FULL_WORD - (FULL_WORD % range);
      draw_tally = draw_tally + 32'd1;
      do begin
        pull_word(w);
      end while (w >= limit);
      r.value = w % range;
    end
    r.draw_total = draw_tally;
    awaited_results.insert(awaited_results.size(), r);
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    draw_result_t want;
    if (rst) begin
      seed_reg = '0;
      draw_tally = '0;
      seed_words(DEFAULT_SEED);
      awaited_results.delete();
    end else begin
      if (seed_we) begin
        seed_reg = seed_wdata;
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result value", m_tdata[31:0], 32'd0);
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata[31:0] !== want.value) begin
            report_mismatch("value", m_tdata[31:0], want.value);
          end
          if (m_tdata[63:32] !== want.draw_total) begin
            report_mismatch("draw_total", m_tdata[63:32], want.draw_total);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_draw(s_tuser, s_tdata);
      end
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Uniform range draw testbench
// Sends directed and random draw and restart requests under random idling on
// both channels, reprograms the seed between phases, and takes the verdict
// from the checker.
// ----------------------------------------------------------------------------
module testbench;
  import mturd_pkg::*;

  localparam int   CYCLE_LIMIT  = 3000000;
  localparam int   PHASE_ITEMS  = 280;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;     // [31:0] range
  logic        s_tuser;     // [0] kind
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;     // [31:0] value, [63:32] draw_total
  logic        seed_we;
  logic [31:0] seed_wdata;
  int          pending;
  int          errors;
  int          cycles;
  bit          quiet;
  int          n_draws;
  int          n_zero;
  int          n_restarts;

  mt19937_uniform_range_draw i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata)
  );

  mturd_draw_checker i_chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .seed_we   (seed_we),
    .seed_wdata(seed_wdata),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side back-pressure in short random bursts.
  int stall_left;
  always @(posedge clk) begin
    if (rst || quiet) begin
      m_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic kind, input logic [31:0] range);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= range;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    if (kind == KIND_RESTART) n_restarts++;
    else if (range == 0) n_zero++;
    else n_draws++;
  endtask

  // Hold off until every result is back, then give the block time to settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    drain_results();
    seed_we <= 1'b1;
    seed_wdata <= value;
    @(posedge clk);
    seed_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_range();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k = $urandom_range(0, 31);
    if (sel < 8) return 32'd0;
    if (sel < 13) return 32'd1;
    if (sel < 38) return 32'($urandom_range(2, 255));
    if (sel < 58) return $urandom();
    if (sel < 73) return (32'd1 << k) + 32'($urandom_range(0, 2)) - 32'd1;
    return {1'b1, 31'($urandom())};
  endfunction

  initial begin
    logic [31:0] phase_seed;
    cycles = 0;
    quiet = 1'b0;
    n_draws = 0;
    n_zero = 0;
    n_restarts = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= KIND_DRAW;
    seed_we <= 1'b0;
    seed_wdata <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the power-up seed, then a restart with seed zero.
    write_seed(32'd0);
    send_request(KIND_DRAW, 32'd1);
    send_request(KIND_DRAW, 32'd2);
    send_request(KIND_DRAW, 32'd0);
    send_request(KIND_DRAW, 32'hFFFFFFFF);
    send_request(KIND_DRAW, 32'h80000000);
    send_request(KIND_DRAW, 32'h80000001);
    send_request(KIND_DRAW, 32'h7FFFFFFF);
    send_request(KIND_DRAW, 32'd3);
    send_request(KIND_DRAW, 32'd0);
    send_request(KIND_RESTART, 32'd0);
    send_request(KIND_DRAW, 32'd6);
    send_request(KIND_DRAW, 32'hFFFFFFFE);
    send_request(KIND_RESTART, 32'hFFFFFFFF);
    send_request(KIND_DRAW, 32'd1);
    write_seed(32'hFFFFFFFF);
    send_request(KIND_RESTART, 32'h5A5A5A5A);
    send_request(KIND_DRAW, 32'd10);
    send_request(KIND_DRAW, 32'h55555555);
    send_request(KIND_DRAW, 32'hAAAAAAAA);

    // Random phases, each under its own seed; the last one ends without idling.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: phase_seed = 32'd1;
        1: phase_seed = 32'd0;
        2: phase_seed = 32'hFFFFFFFF;
        default: phase_seed = $urandom();
      endcase
      write_seed(phase_seed);
      send_request(KIND_RESTART, $urandom());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i > PHASE_ITEMS - 80) quiet = 1'b1;
        if ($urandom_range(0, 99) < 3) send_request(KIND_RESTART, $urandom());
        else send_request(KIND_DRAW, pick_range());
      end
    end

    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    $display("covered %0d counted draws, %0d zero ranges and %0d restarts",
             n_draws, n_zero, n_restarts);
    $display("seeds included zero, all ones and random values; %0d cycles", cycles);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/mturd_pkg.sv
src/mturd_ram.sv
src/mturd_ctrl.sv
src/mturd_dp.sv
src/mt19937_uniform_range_draw.sv
src/mturd_checker.sv
sim/mturd_draw_checker.sv
sim/testbench.sv
